### src/text_console_cell_writer_macros.svh
// Assertion helpers for the console writer RTL.
// Both expect clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// Same-cycle implication.
`define TCW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw: same-cycle check failed");

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw: next-cycle check failed");

`endif

### src/tcw_pkg.sv
package tcw_pkg;

    // command codes carried in tuser
    typedef enum logic [2:0] {
        CMD_PUT    = 3'd0,
        CMD_COLOUR = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_SETCUR = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [6:0] SGR_FG_LO  = 7'd30;
    localparam logic [6:0] SGR_FG_HI  = 7'd37;
    localparam logic [6:0] SGR_BG_LO  = 7'd40;
    localparam logic [6:0] SGR_BG_HI  = 7'd47;
    localparam logic [6:0] SGR_BFG_LO = 7'd90;
    localparam logic [6:0] SGR_BFG_HI = 7'd97;
    localparam logic [6:0] SGR_BBG_LO = 7'd100;
    localparam logic [6:0] SGR_BBG_HI = 7'd107;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    // result field widths
    typedef logic [6:0]  col_out_t;
    typedef logic [4:0]  row_out_t;
    typedef logic [10:0] lin_out_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CHAR,
        ST_BS_RD,
        ST_BS_WR,
        ST_RD_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_HOME,
        CUR_DEC,
        CUR_INC,
        CUR_SET
    } cur_op_t;

    typedef enum logic [1:0] {
        RD_CURSOR,
        RD_POS,
        RD_SCROLL
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_PRINT,
        WR_BS,
        WR_SCROLL,
        WR_BLANK,
        WR_ZERO
    } wr_sel_t;

    typedef struct packed {
        logic    latch;
        cur_op_t cur_op;
        logic    colour_en;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cap_wr;
        logic    cap_rd;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       ch_nl;
        logic       ch_cr;
        logic       ch_bs;
        logic       wrap_pending;
        logic       at_bottom;
        logic       col_zero;
        logic       pos_in_range;
        logic       cnt_scroll_last;
        logic       cnt_last;
        logic       out_free;
    } dp_status_t;

    // SGR colour order to VGA palette index
    function automatic logic [3:0] sgr_map(input logic [3:0] idx);
        logic [3:0] res;
        unique case (idx)
            4'd0:  res = 4'd0;
            4'd1:  res = 4'd4;
            4'd2:  res = 4'd2;
            4'd3:  res = 4'd6;
            4'd4:  res = 4'd1;
            4'd5:  res = 4'd5;
            4'd6:  res = 4'd3;
            4'd7:  res = 4'd7;
            4'd8:  res = 4'd8;
            4'd9:  res = 4'd12;
            4'd10: res = 4'd10;
            4'd11: res = 4'd14;
            4'd12: res = 4'd9;
            4'd13: res = 4'd13;
            4'd14: res = 4'd11;
            4'd15: res = 4'd15;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

### src/tcw_ctrl.sv
module tcw_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  tcw_pkg::dp_status_t    status,
    output tcw_pkg::ctrl_cmd_t     cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;
    logic            resume_char_reg;
    logic            resume_char_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcw_pkg::ST_INIT;
            resume_char_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            resume_char_reg <= resume_char_next;
        end
    end

    assign s_tready = (state_reg == tcw_pkg::ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        resume_char_next = resume_char_reg;
        cmd.latch        = 1'b0;
        cmd.cur_op       = tcw_pkg::CUR_HOLD;
        cmd.colour_en    = 1'b0;
        cmd.rd_en        = 1'b0;
        cmd.rd_sel       = tcw_pkg::RD_CURSOR;
        cmd.wr_en        = 1'b0;
        cmd.wr_sel       = tcw_pkg::WR_PRINT;
        cmd.cap_wr       = 1'b0;
        cmd.cap_rd       = 1'b0;
        cmd.cnt_clr      = 1'b0;
        cmd.cnt_inc      = 1'b0;
        cmd.out_load     = 1'b0;

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                // zero the store after reset
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tcw_pkg::WR_ZERO;
                if (status.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = tcw_pkg::ST_DISPATCH;
                end
            end

            tcw_pkg::ST_DISPATCH:
            begin
                unique case (status.cmd)
                    tcw_pkg::CMD_PUT:
                    begin
                        if (status.wrap_pending)
                        begin
                            cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                            if (status.at_bottom)
                            begin
                                cmd.cnt_clr      = 1'b1;
                                resume_char_next = 1'b1;
                                state_next       = tcw_pkg::ST_SCROLL_RD;
                            end
                            else
                            begin
                                state_next = tcw_pkg::ST_CHAR;
                            end
                        end
                        else
                        begin
                            state_next = tcw_pkg::ST_CHAR;
                        end
                    end
                    tcw_pkg::CMD_COLOUR:
                    begin
                        cmd.colour_en = 1'b1;
                        state_next    = tcw_pkg::ST_FINISH;
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        cmd.cnt_clr      = 1'b1;
                        resume_char_next = 1'b0;
                        state_next       = tcw_pkg::ST_FILL;
                    end
                    tcw_pkg::CMD_SETCUR:
                    begin
                        cmd.cur_op = tcw_pkg::CUR_SET;
                        state_next = tcw_pkg::ST_FINISH;
                    end
                    tcw_pkg::CMD_READ:
                    begin
                        if (status.pos_in_range)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = tcw_pkg::RD_POS;
                            state_next = tcw_pkg::ST_RD_WAIT;
                        end
                        else
                        begin
                            state_next = tcw_pkg::ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_FINISH;
                    end
                endcase
            end

            tcw_pkg::ST_CHAR:
            begin
                priority if (status.ch_nl)
                begin
                    cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                    if (status.at_bottom)
                    begin
                        cmd.cnt_clr      = 1'b1;
                        resume_char_next = 1'b0;
                        state_next       = tcw_pkg::ST_SCROLL_RD;
                    end
                    else
                    begin
                        state_next = tcw_pkg::ST_FINISH;
                    end
                end
                else if (status.ch_cr)
                begin
                    cmd.cur_op = tcw_pkg::CUR_HOME;
                    state_next = tcw_pkg::ST_FINISH;
                end
                else if (status.ch_bs)
                begin
                    if (status.col_zero)
                    begin
                        state_next = tcw_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cmd.cur_op = tcw_pkg::CUR_DEC;
                        state_next = tcw_pkg::ST_BS_RD;
                    end
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = tcw_pkg::WR_PRINT;
                    cmd.cap_wr = 1'b1;
                    cmd.cur_op = tcw_pkg::CUR_INC;
                    state_next = tcw_pkg::ST_FINISH;
                end
            end

            tcw_pkg::ST_BS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tcw_pkg::RD_CURSOR;
                state_next = tcw_pkg::ST_BS_WR;
            end

            tcw_pkg::ST_BS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tcw_pkg::WR_BS;
                cmd.cap_wr = 1'b1;
                state_next = tcw_pkg::ST_FINISH;
            end

            tcw_pkg::ST_RD_WAIT:
            begin
                cmd.cap_rd = 1'b1;
                state_next = tcw_pkg::ST_FINISH;
            end

            tcw_pkg::ST_SCROLL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tcw_pkg::RD_SCROLL;
                state_next = tcw_pkg::ST_SCROLL_WR;
            end

            tcw_pkg::ST_SCROLL_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = tcw_pkg::WR_SCROLL;
                cmd.cnt_inc = 1'b1;
                // counter lands on the first cell of the bottom row
                state_next  = status.cnt_scroll_last ? tcw_pkg::ST_FILL
                                                     : tcw_pkg::ST_SCROLL_RD;
            end

            tcw_pkg::ST_FILL:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tcw_pkg::WR_BLANK;
                if (status.cnt_last)
                begin
                    state_next = resume_char_reg ? tcw_pkg::ST_CHAR : tcw_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end

            tcw_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/tcw_datapath.sv
module tcw_datapath
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::ctrl_cmd_t    cmd,
    output tcw_pkg::dp_status_t   status,
    input  logic [2:0]            s_tuser,
    input  logic [31:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [0:0]            m_tuser,
    output logic [55:0]           m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int LW    = $clog2(CELLS + 1);

    localparam logic [7:0]    COLS_B      = 8'(COLUMNS);
    localparam logic [7:0]    ROWS_B      = 8'(ROWS);
    localparam logic [CW-1:0] COL_END     = CW'(COLUMNS);
    localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
    localparam logic [AW-1:0] CNT_LAST    = AW'(CELLS - 1);
    localparam logic [AW-1:0] CNT_SC_LAST = AW'(CELLS - COLUMNS - 1);

    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;
    logic [AW-1:0] rd_addr_q_reg;

    // latched item
    logic [2:0] cmd_reg;
    logic [7:0] ch_reg;
    logic [6:0] ansi_reg;
    logic [7:0] px_reg;
    logic [7:0] py_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [3:0]    fg_reg;
    logic [3:0]    bg_reg;
    logic [3:0]    fg_next;
    logic [3:0]    bg_next;
    logic [AW-1:0] cnt_reg;

    logic          cell_valid_reg;
    logic [AW-1:0] cell_idx_reg;
    logic [15:0]   cell_data_reg;

    logic                  out_valid_reg;
    tcw_pkg::col_out_t     out_col_reg;
    tcw_pkg::row_out_t     out_row_reg;
    tcw_pkg::lin_out_t     out_lin_reg;
    logic                  out_cvalid_reg;
    tcw_pkg::lin_out_t     out_idx_reg;
    logic [15:0]           out_data_reg;

    logic [AW-1:0] cur_idx;
    logic [AW-1:0] pos_idx;
    logic [LW-1:0] cur_lin;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          pos_ok;

    assign cur_idx = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign pos_idx = AW'(py_reg) * AW'(COLUMNS) + AW'(px_reg);
    assign cur_lin = LW'(row_reg) * LW'(COLUMNS) + LW'(col_reg);
    assign pos_ok  = (px_reg < COLS_B) && (py_reg < ROWS_B);

    always_comb
    begin
        unique case (cmd.rd_sel)
            tcw_pkg::RD_CURSOR: rd_addr = cur_idx;
            tcw_pkg::RD_POS:    rd_addr = pos_idx;
            tcw_pkg::RD_SCROLL: rd_addr = cnt_reg + AW'(COLUMNS);
            default:            rd_addr = cur_idx;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            tcw_pkg::WR_PRINT:
            begin
                wr_addr = cur_idx;
                wr_data = {bg_reg, fg_reg, ch_reg};
            end
            tcw_pkg::WR_BS:
            begin
                wr_addr = cur_idx;
                wr_data = {rd_data_reg[15:8], tcw_pkg::CH_SPACE};
            end
            tcw_pkg::WR_SCROLL:
            begin
                wr_addr = cnt_reg;
                wr_data = rd_data_reg;
            end
            tcw_pkg::WR_BLANK:
            begin
                wr_addr = cnt_reg;
                wr_data = {bg_reg, fg_reg, 8'h00};
            end
            tcw_pkg::WR_ZERO:
            begin
                wr_addr = cnt_reg;
                wr_data = 16'h0000;
            end
            default:
            begin
                wr_addr = cnt_reg;
                wr_data = 16'h0000;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg   <= mem[rd_addr];
            rd_addr_q_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg  <= s_tuser;
            ch_reg   <= s_tdata[7:0];
            ansi_reg <= s_tdata[14:8];
            px_reg   <= s_tdata[22:15];
            py_reg   <= s_tdata[30:23];
        end
    end

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cmd.colour_en)
        begin
            if (ansi_reg >= tcw_pkg::SGR_FG_LO && ansi_reg <= tcw_pkg::SGR_FG_HI)
            begin
                fg_next = tcw_pkg::sgr_map({1'b0, 3'(ansi_reg - tcw_pkg::SGR_FG_LO)});
            end
            else if (ansi_reg >= tcw_pkg::SGR_BG_LO && ansi_reg <= tcw_pkg::SGR_BG_HI)
            begin
                bg_next = tcw_pkg::sgr_map({1'b0, 3'(ansi_reg - tcw_pkg::SGR_BG_LO)});
            end
            else if (ansi_reg >= tcw_pkg::SGR_BFG_LO && ansi_reg <= tcw_pkg::SGR_BFG_HI)
            begin
                fg_next = tcw_pkg::sgr_map({1'b1, 3'(ansi_reg - tcw_pkg::SGR_BFG_LO)});
            end
            else if (ansi_reg >= tcw_pkg::SGR_BBG_LO && ansi_reg <= tcw_pkg::SGR_BBG_HI)
            begin
                bg_next = tcw_pkg::sgr_map({1'b1, 3'(ansi_reg - tcw_pkg::SGR_BBG_LO)});
            end
            else
            begin
                fg_next = fg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            fg_reg         <= tcw_pkg::FG_RESET;
            bg_reg         <= tcw_pkg::BG_RESET;
            cnt_reg        <= '0;
            cell_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;

            unique case (cmd.cur_op)
                tcw_pkg::CUR_HOLD: ;
                tcw_pkg::CUR_NEWLINE:
                begin
                    // at the bottom the row stays; the scroll moves the text
                    col_reg <= '0;
                    if (row_reg != ROW_LAST)
                    begin
                        row_reg <= row_reg + RW'(1);
                    end
                end
                tcw_pkg::CUR_HOME: col_reg <= '0;
                tcw_pkg::CUR_DEC:  col_reg <= col_reg - CW'(1);
                tcw_pkg::CUR_INC:  col_reg <= col_reg + CW'(1);
                tcw_pkg::CUR_SET:
                begin
                    if (px_reg < COLS_B)
                    begin
                        col_reg <= CW'(px_reg);
                    end
                    if (py_reg < ROWS_B)
                    begin
                        row_reg <= RW'(py_reg);
                    end
                end
                default: ;
            endcase

            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end

            if (cmd.latch)
            begin
                cell_valid_reg <= 1'b0;
            end
            else if (cmd.cap_wr || cmd.cap_rd)
            begin
                cell_valid_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // cell fields read as zero unless a cell is reported
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cell_idx_reg  <= '0;
            cell_data_reg <= '0;
        end
        else if (cmd.cap_wr)
        begin
            cell_idx_reg  <= wr_addr;
            cell_data_reg <= wr_data;
        end
        else if (cmd.cap_rd)
        begin
            cell_idx_reg  <= rd_addr_q_reg;
            cell_data_reg <= rd_data_reg;
        end

        if (cmd.out_load)
        begin
            out_col_reg    <= tcw_pkg::col_out_t'(col_reg);
            out_row_reg    <= tcw_pkg::row_out_t'(row_reg);
            out_lin_reg    <= tcw_pkg::lin_out_t'(cur_lin);
            out_cvalid_reg <= cell_valid_reg;
            out_idx_reg    <= tcw_pkg::lin_out_t'(cell_idx_reg);
            out_data_reg   <= cell_data_reg;
        end
    end

    assign status.cmd             = cmd_reg;
    assign status.ch_nl           = (ch_reg == tcw_pkg::CH_NL);
    assign status.ch_cr           = (ch_reg == tcw_pkg::CH_CR);
    assign status.ch_bs           = (ch_reg == tcw_pkg::CH_BS);
    assign status.wrap_pending    = (col_reg >= COL_END);
    assign status.at_bottom       = (row_reg == ROW_LAST);
    assign status.col_zero        = (col_reg == '0);
    assign status.pos_in_range    = pos_ok;
    assign status.cnt_scroll_last = (cnt_reg == CNT_SC_LAST);
    assign status.cnt_last        = (cnt_reg == CNT_LAST);
    assign status.out_free        = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cvalid_reg;
    assign m_tdata  = {6'b0, out_data_reg[15:12], out_data_reg[11:8], out_data_reg[7:0],
                       out_idx_reg, out_lin_reg, out_row_reg, out_col_reg};

endmodule

### src/text_console_cell_writer.sv
// Items are taken one at a time: a new item is accepted only after the result of the
// last one has been loaded, and a result still waiting at the output holds the block.
// A scroll copies each cell up a row (one read port, copy is read then write), then
// blanks the bottom row. A clear writes every cell, one cell written per cycle.
// Reset: asynchronous, active low; a clearing pass then zeroes the store with input held
// off; cursor 0,0, fg 15, bg 0.
`include "text_console_cell_writer_macros.svh"

module text_console_cell_writer
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // cmd
    input  logic [31:0] s_axis_tdata,   // char_code, ansi_code, pos_x, pos_y, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [0:0]  m_axis_tuser,   // cell_valid
    output logic [55:0] m_axis_tdata    // cursor_col, cursor_row, cursor_linear, cell_index,
                                        // cell_char, cell_fg, cell_bg, zero pad
);

    tcw_pkg::ctrl_cmd_t  ctl_cmd;
    tcw_pkg::dp_status_t dp_status;

    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    tcw_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctl_cmd),
        .status   (dp_status),
        .s_tuser  (s_axis_tuser),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tuser  (m_axis_tuser),
        .m_tdata  (m_axis_tdata)
    );

    // one item at a time: no second accept right after the first
    `TCW_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a result is never loaded over one that is still waiting
    `TCW_ASSERT_NOW(a_load_free, ctl_cmd.out_load, dp_status.out_free)
    // no cell reported means all cell fields are zero
    `TCW_ASSERT_NOW(a_cell_zero, m_axis_tvalid && !m_axis_tuser[0],
                    m_axis_tdata[49:23] == 27'd0)

endmodule

### dv/text_console_cell_writer_tb.sv
module text_console_cell_writer_tb;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    localparam int RAND_ITEMS   = 425;
    localparam int QUIET_ITEMS  = 60;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int BRIGHT_OFS   = 8;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    // ANSI order to VGA palette
    localparam logic [3:0] VGA_OF_SGR [16] =
        '{0, 4, 2, 6, 1, 5, 3, 7, 8, 12, 10, 14, 9, 13, 11, 15};

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] lin;
        logic        valid;
        logic [10:0] idx;
        logic [7:0]  ch;
        logic [3:0]  fg;
        logic [3:0]  bg;
    } cell_report_t;

    typedef struct packed {
        logic [2:0]   cmd;
        logic [7:0]   ch;
        logic [6:0]   sgr;
        logic [7:0]   px;
        logic [7:0]   py;
        logic         fixed_on;
        cell_report_t fixed;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    // fixed expectations only where they follow directly from reset state
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{tcw_pkg::CMD_READ,   8'd0,   7'd0,   8'd0,   8'd0,   1'b1,
          '{7'd0, 5'd0, 11'd0, 1'b1, 11'd0, 8'd0, 4'd0, 4'd0}},
        '{tcw_pkg::CMD_READ,   8'd0,   7'd0,   8'd79,  8'd24,  1'b1,
          '{7'd0, 5'd0, 11'd0, 1'b1, 11'd1999, 8'd0, 4'd0, 4'd0}},
        '{tcw_pkg::CMD_READ,   8'd0,   7'd0,   8'd80,  8'd0,   1'b1, '0},
        '{tcw_pkg::CMD_PUT,    8'd65,  7'd0,   8'd0,   8'd0,   1'b1,
          '{7'd1, 5'd0, 11'd1, 1'b1, 11'd0, 8'd65, 4'd15, 4'd0}},
        '{tcw_pkg::CMD_PUT,    tcw_pkg::CH_BS,  7'd0,   8'd0,   8'd0,   1'b1,
          '{7'd0, 5'd0, 11'd0, 1'b1, 11'd0, tcw_pkg::CH_SPACE, 4'd15, 4'd0}},
        '{tcw_pkg::CMD_PUT,    tcw_pkg::CH_BS,  7'd0,   8'd0,   8'd0,   1'b1, '0},
        '{tcw_pkg::CMD_SETCUR, 8'd0,   7'd0,   8'd79,  8'd24,  1'b1,
          '{7'd79, 5'd24, 11'd1999, 1'b0, 11'd0, 8'd0, 4'd0, 4'd0}},
        '{tcw_pkg::CMD_PUT,    8'd255, 7'd0,   8'd0,   8'd0,   1'b1,
          '{7'd80, 5'd24, 11'd2000, 1'b1, 11'd1999, 8'd255, 4'd15, 4'd0}},
        // wrap pending at the bottom row: scroll, then print
        '{tcw_pkg::CMD_PUT,    8'd0,   7'd0,   8'd0,   8'd0,   1'b0, '0},
        '{tcw_pkg::CMD_COLOUR, 8'd0,   tcw_pkg::SGR_FG_LO,  8'd0, 8'd0, 1'b0, '0},
        '{tcw_pkg::CMD_COLOUR, 8'd0,   tcw_pkg::SGR_BG_HI,  8'd0, 8'd0, 1'b0, '0},
        '{tcw_pkg::CMD_COLOUR, 8'd0,   tcw_pkg::SGR_BFG_LO, 8'd0, 8'd0, 1'b0, '0},
        '{tcw_pkg::CMD_COLOUR, 8'd0,   tcw_pkg::SGR_BBG_HI, 8'd0, 8'd0, 1'b0, '0},
        '{tcw_pkg::CMD_COLOUR, 8'd0,   7'd127, 8'd0,   8'd0,   1'b0, '0},
        '{tcw_pkg::CMD_SETCUR, 8'd0,   7'd0,   8'd255, 8'd255, 1'b0, '0},
        '{tcw_pkg::CMD_SETCUR, 8'd0,   7'd0,   8'd0,   8'd255, 1'b0, '0},
        '{tcw_pkg::CMD_PUT,    tcw_pkg::CH_NL,  7'd0,   8'd0,   8'd0,   1'b0, '0},
        '{tcw_pkg::CMD_PUT,    tcw_pkg::CH_CR,  7'd0,   8'd0,   8'd0,   1'b0, '0},
        // backspace right after a wrap is taken does nothing
        '{tcw_pkg::CMD_SETCUR, 8'd0,   7'd0,   8'd79,  8'd5,   1'b0, '0},
        '{tcw_pkg::CMD_PUT,    8'd120, 7'd0,   8'd0,   8'd0,   1'b0, '0},
        '{tcw_pkg::CMD_PUT,    tcw_pkg::CH_BS,  7'd0,   8'd0,   8'd0,   1'b0, '0},
        '{tcw_pkg::CMD_CLEAR,  8'd0,   7'd0,   8'd0,   8'd0,   1'b0, '0},
        '{tcw_pkg::CMD_READ,   8'd0,   7'd0,   8'd0,   8'd0,   1'b0, '0},
        '{CMD_UNUSED_FIRST, 8'd0, 7'd0, 8'd0, 8'd0,   1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [0:0]  m_axis_tuser;
    logic [55:0] m_axis_tdata;

    text_console_cell_writer #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    // console mirror
    logic [15:0] screen [CELLS];
    int          cur_x;
    int          cur_y;
    logic [3:0]  pen_fg;
    logic [3:0]  pen_bg;

    cell_report_t cell_reports [$];
    int           mism_cnt;
    bit           gaps_on;
    int           cyc;

    function automatic void scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLS; i++)
            screen[i] = screen[i + COLS];
        for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
            screen[i] = {pen_bg, pen_fg, 8'd0};
    endfunction

    function automatic void next_row();
        cur_x = 0;
        cur_y++;
        if (cur_y > ROWS - 1)
        begin
            scroll_screen();
            cur_y = ROWS - 1;
        end
    endfunction

    function automatic cell_report_t console_step(input logic [2:0] cmd,
                                                  input logic [7:0] ch,
                                                  input logic [6:0] sgr,
                                                  input logic [7:0] px,
                                                  input logic [7:0] py);
        cell_report_t r;
        int           idx;
        logic         hit;
        r   = '0;
        idx = 0;
        hit = 1'b0;
        case (cmd)
            tcw_pkg::CMD_PUT:
            begin
                if (cur_x >= COLS)
                    next_row();
                if (ch == tcw_pkg::CH_NL)
                    next_row();
                else if (ch == tcw_pkg::CH_CR)
                    cur_x = 0;
                else if (ch == tcw_pkg::CH_BS)
                begin
                    if (cur_x > 0)
                    begin
                        cur_x--;
                        idx = cur_y * COLS + cur_x;
                        screen[idx][7:0] = tcw_pkg::CH_SPACE;
                        hit = 1'b1;
                    end
                end
                else
                begin
                    idx = cur_y * COLS + cur_x;
                    screen[idx] = {pen_bg, pen_fg, ch};
                    cur_x++;
                    hit = 1'b1;
                end
            end
            tcw_pkg::CMD_COLOUR:
            begin
                if (sgr >= tcw_pkg::SGR_FG_LO && sgr <= tcw_pkg::SGR_FG_HI)
                    pen_fg = VGA_OF_SGR[4'(sgr - tcw_pkg::SGR_FG_LO)];
                else if (sgr >= tcw_pkg::SGR_BG_LO && sgr <= tcw_pkg::SGR_BG_HI)
                    pen_bg = VGA_OF_SGR[4'(sgr - tcw_pkg::SGR_BG_LO)];
                else if (sgr >= tcw_pkg::SGR_BFG_LO && sgr <= tcw_pkg::SGR_BFG_HI)
                    pen_fg = VGA_OF_SGR[4'(int'(sgr - tcw_pkg::SGR_BFG_LO) + BRIGHT_OFS)];
                else if (sgr >= tcw_pkg::SGR_BBG_LO && sgr <= tcw_pkg::SGR_BBG_HI)
                    pen_bg = VGA_OF_SGR[4'(int'(sgr - tcw_pkg::SGR_BBG_LO) + BRIGHT_OFS)];
            end
            tcw_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {pen_bg, pen_fg, 8'd0};
            end
            tcw_pkg::CMD_SETCUR:
            begin
                if (int'(px) < COLS)
                    cur_x = int'(px);
                if (int'(py) < ROWS)
                    cur_y = int'(py);
            end
            tcw_pkg::CMD_READ:
            begin
                if (int'(px) < COLS && int'(py) < ROWS)
                begin
                    idx = int'(py) * COLS + int'(px);
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        r.col = 7'(cur_x);
        r.row = 5'(cur_y);
        r.lin = 11'(cur_y * COLS + cur_x);
        if (hit)
        begin
            r.valid = 1'b1;
            r.idx   = 11'(idx);
            r.ch    = screen[idx][7:0];
            r.fg    = screen[idx][11:8];
            r.bg    = screen[idx][15:12];
        end
        return r;
    endfunction

    function automatic string fmt_report(input cell_report_t r);
        return $sformatf("col=%0d row=%0d lin=%0d valid=%0b idx=%0d char=%0d fg=%0d bg=%0d",
                         r.col, r.row, r.lin, r.valid, r.idx, r.ch, r.fg, r.bg);
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                            input logic [6:0] sgr, input logic [7:0] px,
                            input logic [7:0] py, input logic fixed_on,
                            input cell_report_t fixed);
        cell_report_t pred;
        int           gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = int'($urandom_range(1, 15));
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, py, px, sgr, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = console_step(cmd, ch, sgr, px, py);
        cell_reports.push_back(fixed_on ? fixed : pred);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (cell_reports.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("** text_console_cell_writer: FAILED **");
        $finish;
    end

    // sink side back-pressure
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = int'($urandom_range(1, 15)) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        cell_report_t got;
        cell_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.col   = m_axis_tdata[6:0];
            got.row   = m_axis_tdata[11:7];
            got.lin   = m_axis_tdata[22:12];
            got.idx   = m_axis_tdata[33:23];
            got.ch    = m_axis_tdata[41:34];
            got.fg    = m_axis_tdata[45:42];
            got.bg    = m_axis_tdata[49:46];
            got.valid = m_axis_tuser[0];
            if (cell_reports.size() == 0)
            begin
                mism_cnt++;
                if (mism_cnt <= MAX_REPORTS)
                    $display("unexpected item: %s", fmt_report(got));
            end
            else
            begin
                want = cell_reports.pop_front();
                if (got.col !== want.col || got.row !== want.row || got.lin !== want.lin ||
                    got.valid !== want.valid || got.idx !== want.idx ||
                    got.ch !== want.ch || got.fg !== want.fg || got.bg !== want.bg)
                begin
                    mism_cnt++;
                    if (mism_cnt <= MAX_REPORTS)
                        $display("mismatch\n  exp %s\n  got %s",
                                 fmt_report(want), fmt_report(got));
                end
            end
        end
    end

    initial
    begin
        int         n;
        int         pick;
        int         sel;
        logic [2:0] cmd;
        logic [7:0] ch;
        logic [6:0] sgr;
        logic [7:0] px;
        logic [7:0] py;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = tcw_pkg::CMD_PUT;
        s_axis_tdata  = '0;
        mism_cnt      = 0;
        cyc           = 0;
        gaps_on       = 1'b1;
        for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
        cur_x  = 0;
        cur_y  = 0;
        pen_fg = tcw_pkg::FG_RESET;
        pen_bg = tcw_pkg::BG_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
            send_cmd(DIR_TAB[n].cmd, DIR_TAB[n].ch, DIR_TAB[n].sgr, DIR_TAB[n].px,
                     DIR_TAB[n].py, DIR_TAB[n].fixed_on, DIR_TAB[n].fixed);

        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 2)
                drain_results();
            if (n == RAND_ITEMS - QUIET_ITEMS)
                gaps_on = 1'b0;
            pick = int'($urandom_range(0, 99));
            ch   = 8'($urandom_range(0, 255));
            sgr  = 7'($urandom_range(0, 127));
            px   = 8'($urandom_range(0, 255));
            py   = 8'($urandom_range(0, 255));
            if (pick < 55)
            begin
                cmd = tcw_pkg::CMD_PUT;
                sel = int'($urandom_range(0, 99));
                if (sel < 70)
                    ch = 8'($urandom_range(32, 126));
                else if (sel < 77)
                    ch = tcw_pkg::CH_NL;
                else if (sel < 82)
                    ch = tcw_pkg::CH_CR;
                else if (sel < 90)
                    ch = tcw_pkg::CH_BS;
            end
            else if (pick < 67)
            begin
                cmd = tcw_pkg::CMD_COLOUR;
                if ($urandom_range(0, 9) < 7)
                begin
                    sel = int'($urandom_range(0, 7));
                    case ($urandom_range(0, 3))
                        0:       sgr = 7'(tcw_pkg::SGR_FG_LO + sel);
                        1:       sgr = 7'(tcw_pkg::SGR_BG_LO + sel);
                        2:       sgr = 7'(tcw_pkg::SGR_BFG_LO + sel);
                        default: sgr = 7'(tcw_pkg::SGR_BBG_LO + sel);
                    endcase
                end
            end
            else if (pick < 70)
                cmd = tcw_pkg::CMD_CLEAR;
            else if (pick < 82)
            begin
                cmd = tcw_pkg::CMD_SETCUR;
                // mostly in range, often near the right edge to hit wraps
                if ($urandom_range(0, 3) != 0)
                begin
                    px = 8'($urandom_range(0, 1) ? $urandom_range(COLS - 10, COLS - 1)
                                                 : $urandom_range(0, COLS - 1));
                    py = 8'($urandom_range(0, ROWS - 1));
                end
            end
            else if (pick < 97)
            begin
                cmd = tcw_pkg::CMD_READ;
                if ($urandom_range(0, 4) != 0)
                begin
                    px = 8'($urandom_range(0, COLS - 1));
                    py = 8'($urandom_range(0, ROWS - 1));
                end
            end
            else
                cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            send_cmd(cmd, ch, sgr, px, py, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (cell_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mism_cnt == 0)
            $display("** text_console_cell_writer: PASSED **");
        else
            $display("** text_console_cell_writer: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_cell_writer.sv
dv/text_console_cell_writer_tb.sv
